// ----- hw/rtl/hdub_pkg.sv -----
`default_nettype none
package hdub_pkg;

  typedef enum logic [4:0] {
    OP_PAGE     = 5'd0,
    OP_USAGE    = 5'd1,
    OP_USE_MIN  = 5'd2,
    OP_USE_MAX  = 5'd3,
    OP_RID      = 5'd4,
    OP_LOG_MIN  = 5'd5,
    OP_LOG_MAX  = 5'd6,
    OP_PHY_MIN  = 5'd7,
    OP_PHY_MAX  = 5'd8,
    OP_UNIT_EXP = 5'd9,
    OP_UNIT     = 5'd10,
    OP_SIZE     = 5'd11,
    OP_COUNT    = 5'd12,
    OP_INPUT    = 5'd13,
    OP_OUTPUT   = 5'd14,
    OP_FEATURE  = 5'd15,
    OP_COLL     = 5'd16,
    OP_END_COLL = 5'd17,
    OP_IGNORED  = 5'd18
  } op_e;

  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_DESKTOP = 3'd1;
  localparam logic [2:0] KIND_BUTTON  = 3'd2;
  localparam logic [2:0] KIND_VENDOR  = 3'd3;
  localparam logic [2:0] KIND_PADDING = 3'd4;
  localparam logic [2:0] KIND_RID     = 3'd5;

  localparam logic [1:0] IO_NONE    = 2'd0;
  localparam logic [1:0] IO_INPUT   = 2'd1;
  localparam logic [1:0] IO_OUTPUT  = 2'd2;
  localparam logic [1:0] IO_FEATURE = 2'd3;

  localparam logic [31:0] PAGE_DESKTOP     = 32'h0000_0001;
  localparam logic [31:0] PAGE_BUTTON      = 32'h0000_0009;
  localparam logic [31:0] PAGE_VENDOR      = 32'h0000_FF00;
  localparam logic [31:0] COLL_APPLICATION = 32'h0000_0001;
  localparam logic [7:0]  RID_BITS         = 8'd8;

  localparam int unsigned CountW = 16;

  typedef struct packed {
    op_e                op;
    logic [31:0]        vu;
    logic signed [31:0] vs;
  } item_t;

endpackage
`default_nettype wire

// ----- hw/rtl/hdub_if.sv -----
`default_nettype none
interface hdub_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         op;
  logic [31:0]        value_unsigned;
  logic signed [31:0] value_signed;

  modport source (output valid, op, value_unsigned, value_signed, input ready);
  modport sink (input valid, op, value_unsigned, value_signed, output ready);
endinterface

interface hdub_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         usage_kind;
  logic [31:0]        usage_low;
  logic [31:0]        usage_high;
  logic [1:0]         io_kind;
  logic signed [31:0] logical_low;
  logic signed [31:0] logical_high;
  logic signed [31:0] physical_low;
  logic signed [31:0] physical_high;
  logic [7:0]         bits_each;
  logic [15:0]        how_many;
  logic [2:0]         report_number;
  logic               last;

  modport source (output valid, usage_kind, usage_low, usage_high, io_kind, logical_low,
                  logical_high, physical_low, physical_high, bits_each, how_many,
                  report_number, last, input ready);
  modport sink (input valid, usage_kind, usage_low, usage_high, io_kind, logical_low,
                logical_high, physical_low, physical_high, bits_each, how_many,
                report_number, last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/hdub_ram.sv -----
`default_nettype none
module hdub_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/hdub_front.sv -----
`default_nettype none
module hdub_front (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  hdub_in_if.sink       in,
  output logic          valid_o,
  output hdub_pkg::item_t item_o,
  input  wire logic     pop_i
);
  hdub_pkg::item_t buf_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            push;
  hdub_pkg::item_t cls;

  // unknown kinds above the list behave as ignored items
  always_comb begin
    cls.vu = in.value_unsigned;
    cls.vs = in.value_signed;
    if (in.op > 5'd18) begin
      cls.op = hdub_pkg::OP_IGNORED;
    end else begin
      cls.op = hdub_pkg::op_e'(in.op);
    end
  end

  assign in.ready = (cnt_q != 2'd2);
  assign push     = in.valid && in.ready;
  assign valid_o  = (cnt_q != 2'd0);
  assign item_o   = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/hdub_div.sv -----
`default_nettype none
module hdub_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [hdub_pkg::CountW-1:0] dividend_i,
  input  wire logic [hdub_pkg::CountW-1:0] divisor_i,
  output logic                             done_o,
  output logic [hdub_pkg::CountW-1:0]      quotient_o
);
  localparam int unsigned W  = hdub_pkg::CountW;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  rem_q, q_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    trial;

  // restoring division, one quotient bit a cycle
  assign trial      = {rem_q, q_q[W-1]} - {1'b0, dvs_q};
  assign done_o     = done_q;
  assign quotient_o = q_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      q_q   <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= trial[W] ? {rem_q[W-2:0], q_q[W-1]} : trial[W-1:0];
      q_q   <= {q_q[W-2:0], ~trial[W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/hdub_back.sv -----
`default_nettype none
module hdub_back #(
  parameter int unsigned MAX_USAGES  = 16,
  parameter int unsigned MAX_REPORTS = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire hdub_pkg::item_t  item_i,
  output logic                  pop_o,
  hdub_out_if.source            out
);
  localparam int unsigned IW = $clog2(MAX_USAGES);
  localparam int unsigned TW = $clog2(MAX_USAGES + 1);
  localparam int unsigned RW = $clog2(MAX_REPORTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_SWEEP, S_DIV, S_ID, S_RD, S_LD} state_e;

  typedef struct packed {
    logic [2:0]         usage_kind;
    logic [31:0]        usage_low;
    logic [31:0]        usage_high;
    logic [1:0]         io_kind;
    logic signed [31:0] logical_low;
    logic signed [31:0] logical_high;
    logic signed [31:0] physical_low;
    logic signed [31:0] physical_high;
    logic [7:0]         bits_each;
    logic [15:0]        how_many;
    logic [2:0]         report_number;
    logic               last;
  } rec_t;

  state_e             state_q, state_d;
  logic [2:0]         page_q, page_d;
  logic [TW-1:0]      total_q, total_d;
  logic [7:0]         held_q, held_d;
  logic signed [31:0] llo_q, llo_d, lhi_q, lhi_d, plo_q, plo_d, phi_q, phi_d;
  logic [31:0]        lraw_q, lraw_d, praw_q, praw_d;
  logic [7:0]         bits_q, bits_d;
  logic [15:0]        fcnt_q, fcnt_d, each_q, each_d;
  logic [RW-1:0]      rep_q, rep_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [1:0]         io_q, io_d;
  logic               flush_q, flush_d;
  logic [31:0]        sval_q, sval_d;
  logic               shigh_q, shigh_d;
  logic               ovalid_q, ovalid_d;
  rec_t               rec_q, rec_d;

  logic          we_kind, we_low, we_high;
  logic [IW-1:0] waddr;
  logic [2:0]    wkind, rkind;
  logic [31:0]   wlow, whigh, rlow, rhigh;
  logic          div_start, div_done;
  logic [15:0]   div_q, divisor;
  logic          out_free, is_last;
  logic [RW-1:0] rix;
  logic [2:0]    rep_no;

  hdub_ram #(.Width(3), .Depth(MAX_USAGES)) u_kind (
    .clk_i, .we_i(we_kind), .waddr_i(waddr), .wdata_i(wkind), .raddr_i(idx_q), .rdata_o(rkind)
  );
  hdub_ram #(.Width(32), .Depth(MAX_USAGES)) u_low (
    .clk_i, .we_i(we_low), .waddr_i(waddr), .wdata_i(wlow), .raddr_i(idx_q), .rdata_o(rlow)
  );
  hdub_ram #(.Width(32), .Depth(MAX_USAGES)) u_high (
    .clk_i, .we_i(we_high), .waddr_i(waddr), .wdata_i(whigh), .raddr_i(idx_q),
    .rdata_o(rhigh)
  );

  hdub_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(fcnt_q), .divisor_i(divisor),
    .done_o(div_done), .quotient_o(div_q)
  );

  assign out_free = !ovalid_q || out.ready;
  assign rix      = (rep_q == '0) ? '0 : rep_q - 1'b1;
  assign rep_no   = 3'(rix);
  assign is_last  = (TW'(idx_q) == total_q - 1'b1);
  assign divisor  = (total_q == '0) ? 16'd1 : 16'(total_q);

  always_comb begin
    state_d   = state_q;
    page_d    = page_q;
    total_d   = total_q;
    held_d    = held_q;
    llo_d     = llo_q;
    lhi_d     = lhi_q;
    plo_d     = plo_q;
    phi_d     = phi_q;
    lraw_d    = lraw_q;
    praw_d    = praw_q;
    bits_d    = bits_q;
    fcnt_d    = fcnt_q;
    each_d    = each_q;
    rep_d     = rep_q;
    idx_d     = idx_q;
    io_d      = io_q;
    flush_d   = flush_q;
    sval_d    = sval_q;
    shigh_d   = shigh_q;
    ovalid_d  = ovalid_q && !out.ready;
    rec_d     = rec_q;
    pop_o     = 1'b0;
    we_kind   = 1'b0;
    we_low    = 1'b0;
    we_high   = 1'b0;
    waddr     = IW'(total_q);
    wkind     = page_q;
    wlow      = item_i.vu;
    whigh     = item_i.vu;
    div_start = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          case (item_i.op)
            hdub_pkg::OP_PAGE: begin
              if (item_i.vu == hdub_pkg::PAGE_DESKTOP) begin
                page_d = hdub_pkg::KIND_DESKTOP;
              end else if (item_i.vu == hdub_pkg::PAGE_BUTTON) begin
                page_d = hdub_pkg::KIND_BUTTON;
              end else if (item_i.vu == hdub_pkg::PAGE_VENDOR) begin
                page_d = hdub_pkg::KIND_VENDOR;
              end else begin
                page_d = hdub_pkg::KIND_UNKNOWN;
              end
            end
            hdub_pkg::OP_USAGE: begin
              if (total_q < TW'(MAX_USAGES)) begin
                we_kind = 1'b1;
                we_low  = 1'b1;
                we_high = 1'b1;
                total_d = total_q + 1'b1;
              end
            end
            hdub_pkg::OP_USE_MIN, hdub_pkg::OP_USE_MAX: begin
              if (total_q == '0) begin
                // empty store: create one usage carrying the bound
                we_kind = 1'b1;
                we_low  = 1'b1;
                we_high = 1'b1;
                wlow    = (item_i.op == hdub_pkg::OP_USE_MIN) ? item_i.vu : 32'd0;
                whigh   = (item_i.op == hdub_pkg::OP_USE_MAX) ? item_i.vu : 32'd0;
                total_d = TW'(1);
              end else begin
                sval_d  = item_i.vu;
                shigh_d = (item_i.op == hdub_pkg::OP_USE_MAX);
                idx_d   = '0;
                state_d = S_SWEEP;
              end
            end
            hdub_pkg::OP_RID:     held_d = item_i.vu[7:0];
            hdub_pkg::OP_LOG_MIN: llo_d = item_i.vs;
            hdub_pkg::OP_LOG_MAX: begin
              lhi_d  = item_i.vs;
              lraw_d = item_i.vu;
            end
            hdub_pkg::OP_PHY_MIN: plo_d = item_i.vs;
            hdub_pkg::OP_PHY_MAX: begin
              phi_d  = item_i.vs;
              praw_d = item_i.vu;
            end
            hdub_pkg::OP_SIZE: bits_d = (item_i.vu > 32'd255) ? 8'hFF : item_i.vu[7:0];
            hdub_pkg::OP_COUNT: begin
              fcnt_d = (item_i.vu > 32'd65535) ? 16'hFFFF : item_i.vu[15:0];
            end
            hdub_pkg::OP_INPUT, hdub_pkg::OP_OUTPUT, hdub_pkg::OP_FEATURE: begin
              if (item_i.op == hdub_pkg::OP_INPUT) begin
                io_d = hdub_pkg::IO_INPUT;
              end else if (item_i.op == hdub_pkg::OP_OUTPUT) begin
                io_d = hdub_pkg::IO_OUTPUT;
              end else begin
                io_d = hdub_pkg::IO_FEATURE;
              end
              flush_d = 1'b0;
              if (total_q == '0) begin
                we_kind = 1'b1;
                we_low  = 1'b1;
                we_high = 1'b1;
                wkind   = hdub_pkg::KIND_PADDING;
                wlow    = 32'd0;
                whigh   = 32'd0;
                total_d = TW'(1);
              end
              // unsigned repair of a maximum below its minimum
              if (lhi_q < llo_q) begin
                lhi_d = lraw_q;
              end
              if (phi_q < plo_q) begin
                phi_d = praw_q;
              end
              div_start = 1'b1;
              idx_d     = '0;
              state_d   = S_DIV;
            end
            hdub_pkg::OP_COLL: begin
              if (item_i.vu == hdub_pkg::COLL_APPLICATION && rep_q < RW'(MAX_REPORTS)) begin
                rep_d = rep_q + 1'b1;
              end
              if (total_q != '0) begin
                flush_d = 1'b1;
                io_d    = hdub_pkg::IO_NONE;
                idx_d   = '0;
                state_d = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        waddr   = idx_q;
        wlow    = sval_q;
        whigh   = sval_q;
        we_low  = !shigh_q;
        we_high = shigh_q;
        if (is_last) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          each_d  = div_q;
          state_d = (held_q != 8'd0) ? S_ID : S_RD;
        end
      end
      S_ID: begin
        if (out_free) begin
          ovalid_d            = 1'b1;
          rec_d.usage_kind    = hdub_pkg::KIND_RID;
          rec_d.usage_low     = 32'(held_q);
          rec_d.usage_high    = 32'(held_q);
          rec_d.io_kind       = io_q;
          rec_d.logical_low   = '0;
          rec_d.logical_high  = '0;
          rec_d.physical_low  = '0;
          rec_d.physical_high = '0;
          rec_d.bits_each     = hdub_pkg::RID_BITS;
          rec_d.how_many      = 16'd1;
          rec_d.report_number = rep_no;
          rec_d.last          = 1'b0;
          held_d              = 8'd0;
          state_d             = S_RD;
        end
      end
      S_RD: state_d = S_LD;
      S_LD: begin
        if (out_free) begin
          ovalid_d            = 1'b1;
          rec_d.usage_kind    = rkind;
          rec_d.usage_low     = rlow;
          rec_d.usage_high    = rhigh;
          rec_d.io_kind       = io_q;
          rec_d.logical_low   = flush_q ? '0 : llo_q;
          rec_d.logical_high  = flush_q ? '0 : lhi_q;
          rec_d.physical_low  = flush_q ? '0 : plo_q;
          rec_d.physical_high = flush_q ? '0 : phi_q;
          rec_d.bits_each     = flush_q ? 8'd0 : bits_q;
          rec_d.how_many      = flush_q ? 16'd0 : each_q;
          rec_d.report_number = rep_no;
          rec_d.last          = is_last;
          if (is_last) begin
            total_d = '0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      page_q   <= hdub_pkg::KIND_UNKNOWN;
      total_q  <= '0;
      held_q   <= '0;
      llo_q    <= '0;
      lhi_q    <= '0;
      plo_q    <= '0;
      phi_q    <= '0;
      lraw_q   <= '0;
      praw_q   <= '0;
      bits_q   <= '0;
      fcnt_q   <= '0;
      rep_q    <= '0;
      ovalid_q <= 1'b0;
      rec_q    <= '0;
      sval_q   <= '0;
      shigh_q  <= 1'b0;
      each_q   <= '0;
      idx_q    <= '0;
      io_q     <= hdub_pkg::IO_NONE;
      flush_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      page_q   <= page_d;
      total_q  <= total_d;
      held_q   <= held_d;
      llo_q    <= llo_d;
      lhi_q    <= lhi_d;
      plo_q    <= plo_d;
      phi_q    <= phi_d;
      lraw_q   <= lraw_d;
      praw_q   <= praw_d;
      bits_q   <= bits_d;
      fcnt_q   <= fcnt_d;
      rep_q    <= rep_d;
      ovalid_q <= ovalid_d;
      rec_q    <= rec_d;
      sval_q   <= sval_d;
      shigh_q  <= shigh_d;
      each_q   <= each_d;
      idx_q    <= idx_d;
      io_q     <= io_d;
      flush_q  <= flush_d;
    end
  end

  assign out.valid         = ovalid_q;
  assign out.usage_kind    = rec_q.usage_kind;
  assign out.usage_low     = rec_q.usage_low;
  assign out.usage_high    = rec_q.usage_high;
  assign out.io_kind       = rec_q.io_kind;
  assign out.logical_low   = rec_q.logical_low;
  assign out.logical_high  = rec_q.logical_high;
  assign out.physical_low  = rec_q.physical_low;
  assign out.physical_high = rec_q.physical_high;
  assign out.bits_each     = rec_q.bits_each;
  assign out.how_many      = rec_q.how_many;
  assign out.report_number = rec_q.report_number;
  assign out.last          = rec_q.last;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(MAX_USAGES))
    else $error("usage store count beyond capacity");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == S_IDLE)
    else $error("item taken while busy");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LD && out_free && is_last) |=> (total_q == '0 && state_q == S_IDLE))
    else $error("store not emptied after final record");

  a_div_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !div_done) |=> state_q == S_DIV)
    else $error("left divide wait early");
endmodule
`default_nettype wire

// ----- hw/rtl/hid_descriptor_usage_builder.sv -----
// hid descriptor usage builder
// in_i takes one decoded report descriptor item per transfer (op plus the data
// read unsigned and sign-extended); out_o gives usage records, last marking the
// final record caused by one item.
// items enter a two-entry queue and are executed one at a time by the back end.
// a usage minimum or maximum on a non-empty store rewrites the bound of every
// pending usage in the store. input, output and feature items start a serial
// divide for the count split, then give one record per pending usage, after a
// report id record if one is held; a collection flush gives one record per
// pending usage.
// the queue keeps accepting while the back end works, until full, and a finished record sits
// in the output register, so a stalled receiver holds records in place and
// backs up the back end and then in_i, without loss.
// reset clears all properties, the pending count, report id and report counter;
// the usage store itself needs no clearing.
`default_nettype none
module hid_descriptor_usage_builder #(
  parameter int unsigned MAX_USAGES  = 16,
  parameter int unsigned MAX_REPORTS = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hdub_in_if.sink     in_i,
  hdub_out_if.source  out_o
);
  logic            q_valid, q_pop;
  hdub_pkg::item_t q_item;

  hdub_front u_front (
    .clk_i, .rst_ni, .in(in_i), .valid_o(q_valid), .item_o(q_item), .pop_i(q_pop)
  );

  hdub_back #(.MAX_USAGES(MAX_USAGES), .MAX_REPORTS(MAX_REPORTS)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .item_i(q_item), .pop_o(q_pop), .out(out_o)
  );
endmodule
`default_nettype wire
